### rtl/rmsfp_pkg.sv
// Shared types, constants and helpers for the serial frame parser.
package rmsfp_pkg;

    // Configuration register indexes
    localparam logic [2:0] CFG_RSSI_APPENDED = 3'd0;
    localparam logic [2:0] CFG_DATA_IND_ID   = 3'd1;
    localparam logic [2:0] CFG_C_MAP_0       = 3'd2;
    localparam logic [2:0] CFG_C_MAP_1       = 3'd3;
    localparam logic [2:0] CFG_C_MAP_2       = 3'd4;
    localparam logic [2:0] CFG_C_MAP_3       = 3'd5;

    localparam logic [7:0] CMD_START_BYTE   = 8'hFF;
    localparam logic [7:0] TEL_MIN_LEN      = 8'd10;
    localparam logic [7:0] DATA_IND_ID_RST  = 8'd131;
    localparam logic [7:0] RSSI_OFFSET      = 8'd74;

    // Result queue sizing
    localparam int QUEUE_DEPTH = 4;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = PTR_W + 1;

    typedef struct packed {
        logic              frame_end;
        logic [7:0]        data_byte;
        logic [7:0]        message_id;
        logic signed [8:0] signal_dbm;
        logic              rssi_valid;
        logic              checksum_ok;
    } t_result;

    // Up to two results produced by one request
    typedef struct packed {
        logic [1:0] count;
        t_result    first;
        t_result    second;
    } t_push;

    function automatic t_result mk_result(
        input logic              frame_end,
        input logic [7:0]        data_byte,
        input logic [7:0]        message_id,
        input logic signed [8:0] signal_dbm,
        input logic              rssi_valid,
        input logic              checksum_ok
    );
        t_result res;
        res.frame_end   = frame_end;
        res.data_byte   = data_byte;
        res.message_id  = message_id;
        res.signal_dbm  = signal_dbm;
        res.rssi_valid  = rssi_valid;
        res.checksum_ok = checksum_ok;
        return res;
    endfunction

    // Raw module RSSI byte to dBm: upper half is negative two's complement
    function automatic logic signed [8:0] rssi_to_dbm(input logic [7:0] raw);
        logic [8:0] mag;
        logic [8:0] neg_raw;
        neg_raw = 9'd256 - {1'b0, raw};
        if (raw[7]) begin
            mag = {1'b0, neg_raw[8:1]} + {1'b0, RSSI_OFFSET};
        end else begin
            mag = {1'b0, RSSI_OFFSET} - {2'b00, raw[7:1]};
        end
        return $signed(9'd0 - mag);
    endfunction

endpackage

### rtl/radio_module_serial_frame_parser.sv
// Top level of the radio module serial frame parser.
// Takes one received byte per cycle and emits frame items: the length byte and
// payload bytes of each command or telegram frame, then a frame-end item with
// message id, RSSI in dBm and checksum status. A byte is parsed in the cycle it
// is accepted and its results (up to two) are written into a four-entry result
// queue; with the queue empty the first result is visible on the output the
// cycle after acceptance. The output side delivers one item per cycle unless
// stalled. Input stall rises while the queue holds more than two items; with
// the output free the block takes a byte every cycle, except for a stall after
// a byte that yields two results while the queue already holds two (the end of
// a telegram). Configuration writes take effect at the next clock edge.
module radio_module_serial_frame_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_index,
    input  logic [63:0]       i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [7:0]        i_rx_byte,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic              o_frame_end,
    output logic [7:0]        o_data_byte,
    output logic [7:0]        o_message_id,
    output logic signed [8:0] o_signal_dbm,
    output logic              o_rssi_valid,
    output logic              o_checksum_ok
);

    rmsfp_pkg::t_push   push;
    rmsfp_pkg::t_result head;
    logic               accept;

    assign accept = i_in_valid && !o_in_stall;

    rmsfp_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_rx_byte   (i_rx_byte),
        .o_push      (push)
    );

    rmsfp_res_fifo u_res_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_head      (head),
        .o_near_full (o_in_stall)
    );

    assign o_frame_end   = head.frame_end;
    assign o_data_byte   = head.data_byte;
    assign o_message_id  = head.message_id;
    assign o_signal_dbm  = head.signal_dbm;
    assign o_rssi_valid  = head.rssi_valid;
    assign o_checksum_ok = head.checksum_ok;

endmodule

### rtl/rmsfp_parser.sv
// Frame state machine, configuration registers and per-request result generation.
module rmsfp_parser (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [2:0]           i_cfg_index,
    input  logic [63:0]          i_cfg_data,
    input  logic                 i_accept,
    input  logic [7:0]           i_rx_byte,
    output rmsfp_pkg::t_push     o_push
);

    localparam logic [2:0] PH_BOUNDARY    = 3'd0;
    localparam logic [2:0] PH_TEL_CFIELD  = 3'd1;
    localparam logic [2:0] PH_TEL_BODY    = 3'd2;
    localparam logic [2:0] PH_CMD_ID      = 3'd3;
    localparam logic [2:0] PH_CMD_LEN     = 3'd4;
    localparam logic [2:0] PH_CMD_PAYLOAD = 3'd5;
    localparam logic [2:0] PH_CMD_RSSI    = 3'd6;
    localparam logic [2:0] PH_CMD_CS      = 3'd7;

    logic         r_rssi_appended;
    logic [7:0]   r_data_ind_id;
    logic [255:0] r_c_map;

    logic [2:0] r_phase,     n_phase;
    logic [7:0] r_cand_len,  n_cand_len;
    logic [7:0] r_left,      n_left;
    logic [7:0] r_cur_id,    n_cur_id;
    logic [7:0] r_xor,       n_xor;
    logic       r_rssi_pend, n_rssi_pend;
    logic [7:0] r_rssi_held, n_rssi_held;

    rmsfp_pkg::t_push push;
    logic [7:0]       left_dec;
    logic [7:0]       xor_next;
    logic [2:0]       after_payload;
    logic             c_ok;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rssi_appended <= 1'b1;
            r_data_ind_id   <= rmsfp_pkg::DATA_IND_ID_RST;
            r_c_map         <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                rmsfp_pkg::CFG_RSSI_APPENDED: r_rssi_appended <= i_cfg_data[0];
                rmsfp_pkg::CFG_DATA_IND_ID:   r_data_ind_id   <= i_cfg_data[7:0];
                rmsfp_pkg::CFG_C_MAP_0:       r_c_map[63:0]    <= i_cfg_data;
                rmsfp_pkg::CFG_C_MAP_1:       r_c_map[127:64]  <= i_cfg_data;
                rmsfp_pkg::CFG_C_MAP_2:       r_c_map[191:128] <= i_cfg_data;
                rmsfp_pkg::CFG_C_MAP_3:       r_c_map[255:192] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign left_dec      = r_left - 8'd1;
    assign xor_next      = r_xor ^ i_rx_byte;
    assign after_payload = r_rssi_pend ? PH_CMD_RSSI : PH_CMD_CS;
    assign c_ok          = r_c_map[i_rx_byte];

    always_comb begin
        n_phase     = r_phase;
        n_cand_len  = r_cand_len;
        n_left      = r_left;
        n_cur_id    = r_cur_id;
        n_xor       = r_xor;
        n_rssi_pend = r_rssi_pend;
        n_rssi_held = r_rssi_held;
        push        = '0;

        case (r_phase)
            PH_BOUNDARY: begin
                if (i_rx_byte == rmsfp_pkg::CMD_START_BYTE) begin
                    n_xor   = rmsfp_pkg::CMD_START_BYTE;
                    n_phase = PH_CMD_ID;
                end else begin
                    n_cand_len = i_rx_byte;
                    n_phase    = PH_TEL_CFIELD;
                end
            end
            PH_TEL_CFIELD: begin
                if (r_cand_len >= rmsfp_pkg::TEL_MIN_LEN && c_ok) begin
                    n_cur_id    = 8'd0;
                    push.count  = 2'd2;
                    push.first  = rmsfp_pkg::mk_result(1'b0, r_cand_len, 8'd0, '0, 1'b0, 1'b0);
                    push.second = rmsfp_pkg::mk_result(1'b0, i_rx_byte, 8'd0, '0, 1'b0, 1'b0);
                    n_left      = r_cand_len - 8'd1;
                    n_phase     = PH_TEL_BODY;
                end else begin
                    // restart the hunt at the newer byte
                    n_cand_len = i_rx_byte;
                end
            end
            PH_TEL_BODY: begin
                push.count = 2'd1;
                push.first = rmsfp_pkg::mk_result(1'b0, i_rx_byte, 8'd0, '0, 1'b0, 1'b0);
                n_left     = left_dec;
                if (left_dec == 8'd0) begin
                    push.count = 2'd2;
                    if (r_rssi_appended) begin
                        push.second = rmsfp_pkg::mk_result(1'b1, 8'd0, 8'd0,
                            rmsfp_pkg::rssi_to_dbm(i_rx_byte), 1'b1, 1'b1);
                    end else begin
                        push.second = rmsfp_pkg::mk_result(1'b1, 8'd0, 8'd0, '0, 1'b0, 1'b1);
                    end
                    n_phase = PH_BOUNDARY;
                end
            end
            PH_CMD_ID: begin
                n_cur_id    = i_rx_byte;
                n_xor       = xor_next;
                n_rssi_pend = r_rssi_appended && (i_rx_byte == r_data_ind_id);
                n_phase     = PH_CMD_LEN;
            end
            PH_CMD_LEN: begin
                n_xor  = xor_next;
                n_left = i_rx_byte;
                if (i_rx_byte != 8'd0) begin
                    push.count = 2'd1;
                    push.first = rmsfp_pkg::mk_result(1'b0, i_rx_byte, r_cur_id, '0, 1'b0, 1'b0);
                    n_phase    = PH_CMD_PAYLOAD;
                end else begin
                    n_phase = after_payload;
                end
            end
            PH_CMD_PAYLOAD: begin
                n_xor      = xor_next;
                push.count = 2'd1;
                push.first = rmsfp_pkg::mk_result(1'b0, i_rx_byte, r_cur_id, '0, 1'b0, 1'b0);
                n_left     = left_dec;
                if (left_dec == 8'd0) begin
                    n_phase = after_payload;
                end
            end
            PH_CMD_RSSI: begin
                n_xor       = xor_next;
                n_rssi_held = i_rx_byte;
                n_phase     = PH_CMD_CS;
            end
            default: begin
                push.count = 2'd1;
                if (r_rssi_pend) begin
                    push.first = rmsfp_pkg::mk_result(1'b1, 8'd0, r_cur_id,
                        rmsfp_pkg::rssi_to_dbm(r_rssi_held), 1'b1, i_rx_byte == r_xor);
                end else begin
                    push.first = rmsfp_pkg::mk_result(1'b1, 8'd0, r_cur_id, '0, 1'b0,
                        i_rx_byte == r_xor);
                end
                n_phase = PH_BOUNDARY;
            end
        endcase
    end

    always_comb begin
        o_push = push;
        if (!i_accept) begin
            o_push.count = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_BOUNDARY;
            r_cand_len  <= '0;
            r_left      <= '0;
            r_cur_id    <= '0;
            r_xor       <= '0;
            r_rssi_pend <= 1'b0;
            r_rssi_held <= '0;
        end else if (i_accept) begin
            r_phase     <= n_phase;
            r_cand_len  <= n_cand_len;
            r_left      <= n_left;
            r_cur_id    <= n_cur_id;
            r_xor       <= n_xor;
            r_rssi_pend <= n_rssi_pend;
            r_rssi_held <= n_rssi_held;
        end
    end

endmodule

### rtl/rmsfp_res_fifo.sv
// Small result queue: up to two in a cycle, one out unless stalled.
module rmsfp_res_fifo (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rmsfp_pkg::t_push     i_push,
    input  logic                 i_out_stall,
    output logic                 o_out_valid,
    output rmsfp_pkg::t_result   o_head,
    output logic                 o_near_full
);

    rmsfp_pkg::t_result r_mem [rmsfp_pkg::QUEUE_DEPTH];

    logic [rmsfp_pkg::PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [rmsfp_pkg::PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [rmsfp_pkg::CNT_W-1:0] r_count,  n_count;
    logic [rmsfp_pkg::PTR_W-1:0] wr_ptr_next;
    logic                        pop;

    assign pop         = o_out_valid && !i_out_stall;
    assign o_out_valid = r_count != '0;
    assign o_head      = r_mem[r_rd_ptr];
    // hold the input while fewer than two slots are free
    assign o_near_full = r_count > rmsfp_pkg::CNT_W'(rmsfp_pkg::QUEUE_DEPTH - 2);
    assign wr_ptr_next = r_wr_ptr + rmsfp_pkg::PTR_W'(1);

    always_comb begin
        n_wr_ptr = r_wr_ptr + rmsfp_pkg::PTR_W'(i_push.count);
        n_rd_ptr = pop ? r_rd_ptr + rmsfp_pkg::PTR_W'(1) : r_rd_ptr;
        n_count  = r_count + rmsfp_pkg::CNT_W'(i_push.count)
                   - rmsfp_pkg::CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr_ptr_next] <= i_push.second;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

endmodule

### rtl/rmsfp_checker.sv
// Port-level checks for the serial frame parser, bound to the top level.
module rmsfp_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic              o_frame_end,
    input logic [7:0]        o_data_byte,
    input logic [7:0]        o_message_id,
    input logic signed [8:0] o_signal_dbm,
    input logic              o_rssi_valid,
    input logic              o_checksum_ok
);

    // Queue comes out of reset empty
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result valid right after reset");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_frame_end)
            && $stable(o_data_byte) && $stable(o_message_id) && $stable(o_signal_dbm))
        else $error("stalled result changed");

    a_data_item_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_frame_end |-> !o_rssi_valid && o_signal_dbm == 9'sd0
            && !o_checksum_ok)
        else $error("data item carries frame-end status");

    a_rssi_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_end |-> o_data_byte == 8'd0
            && (o_rssi_valid ? (o_signal_dbm <= -9'sd11 && o_signal_dbm >= -9'sd138)
                             : o_signal_dbm == 9'sd0))
        else $error("frame-end RSSI out of range");

endmodule

bind radio_module_serial_frame_parser rmsfp_checker u_rmsfp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_out_valid   (o_out_valid),
    .i_out_stall   (i_out_stall),
    .o_frame_end   (o_frame_end),
    .o_data_byte   (o_data_byte),
    .o_message_id  (o_message_id),
    .o_signal_dbm  (o_signal_dbm),
    .o_rssi_valid  (o_rssi_valid),
    .o_checksum_ok (o_checksum_ok)
);

### dv/tb_radio_module_serial_frame_parser.sv
// Self-checking testbench for the radio module serial frame parser.
module tb_radio_module_serial_frame_parser;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_LIMIT = 2000;
    localparam int HOLD_CYCLES = 200;

    typedef enum logic [2:0] {
        PH_BOUNDARY,
        PH_TEL_C,
        PH_TEL_BODY,
        PH_CMD_ID,
        PH_CMD_LEN,
        PH_CMD_PAYLOAD,
        PH_CMD_RSSI,
        PH_CMD_CS
    } t_parse_phase;

    logic              clk;
    logic              rst_n;
    logic              cfg_we;
    logic [2:0]        cfg_index;
    logic [63:0]       cfg_data;
    logic              in_valid;
    logic              in_stall;
    logic [7:0]        rx_byte;
    logic              out_valid;
    logic              out_stall;
    logic              frame_end;
    logic [7:0]        data_byte;
    logic [7:0]        message_id;
    logic signed [8:0] signal_dbm;
    logic              rssi_valid;
    logic              checksum_ok;

    radio_module_serial_frame_parser dut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_cfg_we      (cfg_we),
        .i_cfg_index   (cfg_index),
        .i_cfg_data    (cfg_data),
        .i_in_valid    (in_valid),
        .o_in_stall    (in_stall),
        .i_rx_byte     (rx_byte),
        .o_out_valid   (out_valid),
        .i_out_stall   (out_stall),
        .o_frame_end   (frame_end),
        .o_data_byte   (data_byte),
        .o_message_id  (message_id),
        .o_signal_dbm  (signal_dbm),
        .o_rssi_valid  (rssi_valid),
        .o_checksum_ok (checksum_ok)
    );

    // Configuration copy kept by the parser model
    logic        m_rssi_app;
    logic [7:0]  m_ind_id;
    logic [63:0] m_cmap [4];

    // Parser model state
    t_parse_phase ph;
    logic [7:0]   cand_len;
    logic [7:0]   left;
    logic [7:0]   cur_id;
    logic [7:0]   xacc;
    logic         rssi_pend;
    logic [7:0]   rssi_held;

    rmsfp_pkg::t_result expected_frame_items[$];

    int  cycle_count;
    int  sent_bytes;
    int  items_checked;
    int  frame_ends_seen;
    int  in_stall_cycles;
    int  cfg_writes;
    int  mismatches;
    bit  idle_on;
    int  hold_requests;
    int  hold_served;
    int  hold_left;
    int  stall_left;

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("FAIL radio_module_serial_frame_parser");
            $finish;
        end
    end

    function automatic logic signed [8:0] raw_to_dbm(input logic [7:0] raw);
        int v;
        if (raw >= 8'd128) begin
            v = (int'(raw) - 256) / 2 - int'(rmsfp_pkg::RSSI_OFFSET);
        end else begin
            v = int'(raw) / 2 - int'(rmsfp_pkg::RSSI_OFFSET);
        end
        return v[8:0];
    endfunction

    function automatic bit c_ok(input logic [7:0] c);
        return m_cmap[c[7:6]][c[5:0]];
    endfunction

    function automatic void add_item(input logic e, input logic [7:0] b, input logic [7:0] id,
                                     input logic signed [8:0] dbm, input logic rv,
                                     input logic ok);
        rmsfp_pkg::t_result r;
        r.frame_end   = e;
        r.data_byte   = b;
        r.message_id  = id;
        r.signal_dbm  = dbm;
        r.rssi_valid  = rv;
        r.checksum_ok = ok;
        expected_frame_items.push_back(r);
    endfunction

    function automatic void model_reset();
        m_rssi_app = 1'b1;
        m_ind_id   = rmsfp_pkg::DATA_IND_ID_RST;
        for (int i = 0; i < 4; i++) m_cmap[i] = '0;
        ph        = PH_BOUNDARY;
        cand_len  = '0;
        left      = '0;
        cur_id    = '0;
        xacc      = '0;
        rssi_pend = 1'b0;
        rssi_held = '0;
    endfunction

    // Advance the parser model by one accepted byte
    function automatic void parse_byte(input logic [7:0] b);
        case (ph)
            PH_BOUNDARY: begin
                if (b == rmsfp_pkg::CMD_START_BYTE) begin
                    xacc = b;
                    ph   = PH_CMD_ID;
                end else begin
                    cand_len = b;
                    ph       = PH_TEL_C;
                end
            end
            PH_TEL_C: begin
                if (cand_len >= rmsfp_pkg::TEL_MIN_LEN && c_ok(b)) begin
                    cur_id = '0;
                    add_item(1'b0, cand_len, 8'd0, 9'sd0, 1'b0, 1'b0);
                    add_item(1'b0, b, 8'd0, 9'sd0, 1'b0, 1'b0);
                    left = cand_len - 8'd1;
                    ph   = PH_TEL_BODY;
                end else begin
                    // resync: newer byte becomes the next length candidate
                    cand_len = b;
                end
            end
            PH_TEL_BODY: begin
                add_item(1'b0, b, 8'd0, 9'sd0, 1'b0, 1'b0);
                left = left - 8'd1;
                if (left == 8'd0) begin
                    if (m_rssi_app) add_item(1'b1, 8'd0, 8'd0, raw_to_dbm(b), 1'b1, 1'b1);
                    else            add_item(1'b1, 8'd0, 8'd0, 9'sd0, 1'b0, 1'b1);
                    ph = PH_BOUNDARY;
                end
            end
            PH_CMD_ID: begin
                cur_id    = b;
                xacc      = xacc ^ b;
                rssi_pend = m_rssi_app && (b == m_ind_id);
                ph        = PH_CMD_LEN;
            end
            PH_CMD_LEN: begin
                xacc = xacc ^ b;
                left = b;
                if (b != 8'd0) begin
                    add_item(1'b0, b, cur_id, 9'sd0, 1'b0, 1'b0);
                    ph = PH_CMD_PAYLOAD;
                end else begin
                    ph = rssi_pend ? PH_CMD_RSSI : PH_CMD_CS;
                end
            end
            PH_CMD_PAYLOAD: begin
                xacc = xacc ^ b;
                add_item(1'b0, b, cur_id, 9'sd0, 1'b0, 1'b0);
                left = left - 8'd1;
                if (left == 8'd0) ph = rssi_pend ? PH_CMD_RSSI : PH_CMD_CS;
            end
            PH_CMD_RSSI: begin
                xacc      = xacc ^ b;
                rssi_held = b;
                ph        = PH_CMD_CS;
            end
            default: begin
                add_item(1'b1, 8'd0, cur_id, rssi_pend ? raw_to_dbm(rssi_held) : 9'sd0,
                         rssi_pend, b == xacc);
                ph = PH_BOUNDARY;
            end
        endcase
    endfunction

    function automatic void report_mismatch(input string tag, input rmsfp_pkg::t_result want,
                                            input rmsfp_pkg::t_result got);
        mismatches++;
        if (mismatches <= 10) begin
            $display("%s: expected end=%0b byte=%02h id=%02h dbm=%0d rv=%0b ok=%0b", tag,
                     want.frame_end, want.data_byte, want.message_id, want.signal_dbm,
                     want.rssi_valid, want.checksum_ok);
            $display("    got      end=%0b byte=%02h id=%02h dbm=%0d rv=%0b ok=%0b",
                     got.frame_end, got.data_byte, got.message_id, got.signal_dbm,
                     got.rssi_valid, got.checksum_ok);
        end
    endfunction

    // Predict on every accepted request, check every delivered result
    always @(posedge clk) begin
        rmsfp_pkg::t_result got;
        rmsfp_pkg::t_result want;
        if (rst_n) begin
            if (in_valid && !in_stall) parse_byte(rx_byte);
            if (in_valid && in_stall) in_stall_cycles++;
            if (out_valid && !out_stall) begin
                got.frame_end   = frame_end;
                got.data_byte   = data_byte;
                got.message_id  = message_id;
                got.signal_dbm  = signal_dbm;
                got.rssi_valid  = rssi_valid;
                got.checksum_ok = checksum_ok;
                items_checked++;
                if (frame_end) frame_ends_seen++;
                if (expected_frame_items.size() == 0) begin
                    want = '0;
                    report_mismatch("unexpected result", want, got);
                end else begin
                    want = expected_frame_items.pop_front();
                    if (got.frame_end !== want.frame_end || got.data_byte !== want.data_byte
                        || got.message_id !== want.message_id
                        || got.signal_dbm !== want.signal_dbm
                        || got.rssi_valid !== want.rssi_valid
                        || got.checksum_ok !== want.checksum_ok)
                        report_mismatch("result mismatch", want, got);
                end
            end
        end
    end

    // Output side: random stall bursts plus an occasional long hold
    always @(negedge clk) begin
        if (hold_requests != hold_served) begin
            hold_served++;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            out_stall <= 1'b1;
        end else if (idle_on && rst_n && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 13) - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 4) == 0) gap = $urandom_range(1, 13);
        repeat (gap) begin
            @(negedge clk);
            in_valid <= 1'b0;
        end
        @(negedge clk);
        in_valid <= 1'b1;
        rx_byte  <= b;
        do @(posedge clk); while (in_stall);
        sent_bytes++;
    endtask

    // Drop valid and wait for every predicted result, then a few spare cycles
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_frame_items.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [2:0] idx, input logic [63:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            rmsfp_pkg::CFG_RSSI_APPENDED: m_rssi_app = val[0];
            rmsfp_pkg::CFG_DATA_IND_ID:   m_ind_id   = val[7:0];
            rmsfp_pkg::CFG_C_MAP_0:       m_cmap[0]  = val;
            rmsfp_pkg::CFG_C_MAP_1:       m_cmap[1]  = val;
            rmsfp_pkg::CFG_C_MAP_2:       m_cmap[2]  = val;
            rmsfp_pkg::CFG_C_MAP_3:       m_cmap[3]  = val;
            default: ;
        endcase
        cfg_writes++;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic apply_config(input logic rssi_app, input logic [7:0] ind_id,
                                input logic [63:0] m0, input logic [63:0] m1,
                                input logic [63:0] m2, input logic [63:0] m3);
        write_cfg(rmsfp_pkg::CFG_RSSI_APPENDED, {63'd0, rssi_app});
        write_cfg(rmsfp_pkg::CFG_DATA_IND_ID, {56'd0, ind_id});
        write_cfg(rmsfp_pkg::CFG_C_MAP_0, m0);
        write_cfg(rmsfp_pkg::CFG_C_MAP_1, m1);
        write_cfg(rmsfp_pkg::CFG_C_MAP_2, m2);
        write_cfg(rmsfp_pkg::CFG_C_MAP_3, m3);
    endtask

    // Command frame (bad_cs corrupts the checksum); RSSI byte added when expected
    task automatic send_command(input logic [7:0] id, input logic [7:0] len,
                                input logic [7:0] rssi_raw, input bit bad_cs);
        logic [7:0] x;
        logic [7:0] p;
        x = rmsfp_pkg::CMD_START_BYTE;
        send_byte(rmsfp_pkg::CMD_START_BYTE);
        send_byte(id);
        x = x ^ id;
        send_byte(len);
        x = x ^ len;
        repeat (int'(len)) begin
            p = 8'($urandom);
            send_byte(p);
            x = x ^ p;
        end
        if (m_rssi_app && id == m_ind_id) begin
            send_byte(rssi_raw);
            x = x ^ rssi_raw;
        end
        if (bad_cs) x = x ^ 8'($urandom_range(1, 255));
        send_byte(x);
    endtask

    // Telegram: length byte, C field, then len-1 more bytes ending in last_b
    task automatic send_telegram(input logic [7:0] len, input logic [7:0] c,
                                 input logic [7:0] last_b);
        send_byte(len);
        send_byte(c);
        repeat (int'(len) - 2) send_byte(8'($urandom));
        send_byte(last_b);
    endtask

    function automatic bit pick_c(input bit want_valid, output logic [7:0] c);
        logic [7:0] start;
        start = 8'($urandom);
        c = start;
        for (int i = 0; i < 256; i++) begin
            c = start + 8'(i);
            if (c_ok(c) == want_valid) return 1'b1;
        end
        return 1'b0;
    endfunction

    task automatic gen_frame();
        int         kind;
        logic [7:0] c;
        logic [7:0] len;
        kind = $urandom_range(0, 99);
        if (kind < 40) begin
            if ($urandom_range(0, 7) == 0)       len = 8'd0;
            else if ($urandom_range(0, 29) == 0) len = 8'($urandom_range(13, 100));
            else                                 len = 8'($urandom_range(1, 12));
            send_command(($urandom_range(0, 2) == 0) ? m_ind_id : 8'($urandom), len,
                         8'($urandom), $urandom_range(0, 5) == 0);
        end else if (kind < 80) begin
            if ($urandom_range(0, 29) == 0) len = 8'($urandom_range(25, 120));
            else                            len = 8'($urandom_range(10, 24));
            if (pick_c(1'b1, c)) send_telegram(len, c, 8'($urandom));
            else                 send_byte(8'($urandom));
        end else if (kind < 90) begin
            repeat ($urandom_range(1, 4))
                send_byte(($urandom_range(0, 3) == 0) ? rmsfp_pkg::CMD_START_BYTE
                                                      : 8'($urandom));
        end else begin
            // broken telegram start: short length or bad C field
            if ($urandom_range(0, 1) == 0) begin
                send_byte(8'($urandom_range(0, 9)));
                if (pick_c(1'b1, c)) send_byte(c);
            end else begin
                send_byte(8'($urandom_range(10, 254)));
                if (pick_c(1'b0, c)) send_byte(c);
            end
        end
    endtask

    task automatic test_reset_defaults();
        send_command(rmsfp_pkg::DATA_IND_ID_RST, 8'd3, 8'h00, 1'b0);
        send_command(8'h00, 8'd0, 8'h00, 1'b0);
        send_command(rmsfp_pkg::DATA_IND_ID_RST, 8'd0, 8'hFF, 1'b0);
        // no C field is valid yet: leave the hunt holding 0x44 as candidate
        send_byte(8'h0C);
        send_byte(8'h44);
        settle();
    endtask

    task automatic test_telegrams();
        apply_config(1'b1, rmsfp_pkg::DATA_IND_ID_RST, 64'h0000_0000_0000_0100,
                     64'h0000_0000_0008_0050, 64'h0000_0000_0400_0000,
                     64'h0000_0000_0000_0010);
        // hunt passes over 0xFF without starting a command
        send_byte(8'h03);
        send_byte(rmsfp_pkg::CMD_START_BYTE);
        send_telegram(8'd10, 8'h44, 8'h80);
        // length 9 with a valid C field is rejected, resync on the newer byte
        send_byte(8'd9);
        send_byte(8'h44);
        send_telegram(8'd11, 8'h46, 8'h7F);
        send_telegram(8'd12, 8'h08, 8'h00);
        send_telegram(8'd10, 8'h9A, 8'hFF);
        send_telegram(8'd13, 8'hC4, 8'h01);
        settle();
    endtask

    task automatic test_commands();
        send_command(rmsfp_pkg::DATA_IND_ID_RST, 8'd3, 8'h80, 1'b0);
        send_command(rmsfp_pkg::DATA_IND_ID_RST, 8'd0, 8'h7F, 1'b1);
        send_command(8'h05, 8'd0, 8'h00, 1'b0);
        send_command(8'h44, 8'd2, 8'h00, 1'b1);
        send_command(8'hFF, 8'd1, 8'h00, 1'b0);
        send_command(8'h00, 8'd1, 8'h00, 1'b0);
        settle();
    endtask

    task automatic test_config_extremes();
        apply_config(1'b0, 8'h00, '1, '1, '1, '1);
        send_telegram(8'd10, 8'h00, 8'hFF);
        send_telegram(8'd10, 8'hFF, 8'h00);
        send_command(8'h00, 8'd2, 8'h00, 1'b0);
        settle();
        apply_config(1'b1, 8'hFF, '0, '0, '0, '1);
        send_command(8'hFF, 8'd1, 8'h90, 1'b0);
        send_telegram(8'd10, 8'hC0, 8'h55);
        settle();
    endtask

    task automatic test_backpressure();
        apply_config(1'b1, rmsfp_pkg::DATA_IND_ID_RST, '1, '1, '1, '1);
        idle_on = 1'b0;
        hold_requests++;
        send_telegram(8'd20, 8'h44, 8'($urandom));
        send_command(rmsfp_pkg::DATA_IND_ID_RST, 8'd6, 8'($urandom), 1'b0);
        send_command(8'h12, 8'd4, 8'h00, 1'b0);
        settle();
        idle_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        int start;
        for (int round = 0; round < 5; round++) begin
            case (round)
                0: apply_config(1'b1, rmsfp_pkg::DATA_IND_ID_RST,
                                {$urandom & $urandom, $urandom & $urandom},
                                {$urandom & $urandom, $urandom & $urandom},
                                {$urandom & $urandom, $urandom & $urandom},
                                {$urandom & $urandom, $urandom & $urandom});
                1: apply_config(1'b0, 8'($urandom), '1, '1, '1, '1);
                2: apply_config(1'b1, 8'hFF, {$urandom, $urandom}, {$urandom, $urandom},
                                {$urandom, $urandom}, {$urandom, $urandom});
                3: apply_config(1'b1, 8'($urandom), '0, {$urandom, $urandom},
                                {$urandom, $urandom}, '0);
                default: apply_config(1'($urandom), rmsfp_pkg::DATA_IND_ID_RST,
                                      {$urandom, $urandom}, {$urandom, $urandom},
                                      {$urandom, $urandom}, {$urandom, $urandom});
            endcase
            start = sent_bytes;
            while (sent_bytes - start < 50) gen_frame();
            settle();
        end
    endtask

    task automatic test_no_idle_tail();
        int start;
        idle_on = 1'b0;
        start = sent_bytes;
        while (sent_bytes - start < 50) gen_frame();
    endtask

    initial begin
        int waited;
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        in_valid        = 1'b0;
        rx_byte         = '0;
        out_stall       = 1'b0;
        idle_on         = 1'b1;
        cycle_count     = 0;
        sent_bytes      = 0;
        items_checked   = 0;
        frame_ends_seen = 0;
        in_stall_cycles = 0;
        cfg_writes      = 0;
        mismatches      = 0;
        hold_requests   = 0;
        hold_served     = 0;
        hold_left       = 0;
        stall_left      = 0;
        model_reset();
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_defaults();
        test_telegrams();
        test_commands();
        test_config_extremes();
        test_backpressure();
        test_random_traffic();
        test_no_idle_tail();

        @(negedge clk);
        in_valid <= 1'b0;
        waited = 0;
        while (expected_frame_items.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
        repeat (10) @(posedge clk);
        if (expected_frame_items.size() != 0) begin
            $display("%0d predicted results never arrived", expected_frame_items.size());
            mismatches += expected_frame_items.size();
        end

        $display("Run covered %0d serial bytes and %0d checked items (%0d frame ends).",
                 sent_bytes, items_checked, frame_ends_seen);
        $display("Register writes: %0d, cycles with input held off: %0d, failures: %0d.",
                 cfg_writes, in_stall_cycles, mismatches);
        if (mismatches == 0) begin
            $display("PASS radio_module_serial_frame_parser");
        end else begin
            $display("FAIL radio_module_serial_frame_parser");
        end
        $finish;
    end

endmodule
